// File: hdl/morse_code_codec_macros.svh
// assertion macros shared by the morse codec modules
`ifndef MORSE_CODE_CODEC_MACROS_SVH
`define MORSE_CODE_CODEC_MACROS_SVH

// same-cycle implication, checked out of reset
`define MCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mcc_pkg.sv
// types, character codes and code tables of the morse codec
`default_nettype none

package mcc_pkg;

  // most results one item can cause: four symbols and a space
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = 3;
  // node index width that covers the deepest tree the codec supports
  localparam int unsigned NodeW      = 8;

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_DASH  = 8'h5f;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7a;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // results caused by one item
  typedef struct packed {
    logic [MaxResults-1:0][7:0] chars;
    logic [CntW-1:0]            cnt;
    logic                       err;
  } burst_t;

  // code of a letter: {length, symbols}, symbol i in bit i, 1 for a dash
  function automatic logic [6:0] mcc_code(input logic [4:0] idx);
    logic [6:0] code;
    case (idx)
      5'd0:    code = {3'd2, 4'b0010};
      5'd1:    code = {3'd4, 4'b0001};
      5'd2:    code = {3'd4, 4'b0101};
      5'd3:    code = {3'd3, 4'b0001};
      5'd4:    code = {3'd1, 4'b0000};
      5'd5:    code = {3'd4, 4'b0100};
      5'd6:    code = {3'd3, 4'b0011};
      5'd7:    code = {3'd4, 4'b0000};
      5'd8:    code = {3'd2, 4'b0000};
      5'd9:    code = {3'd4, 4'b1110};
      5'd10:   code = {3'd3, 4'b0101};
      5'd11:   code = {3'd4, 4'b0010};
      5'd12:   code = {3'd2, 4'b0011};
      5'd13:   code = {3'd2, 4'b0001};
      5'd14:   code = {3'd3, 4'b0111};
      5'd15:   code = {3'd4, 4'b0110};
      5'd16:   code = {3'd4, 4'b1011};
      5'd17:   code = {3'd3, 4'b0010};
      5'd18:   code = {3'd3, 4'b0000};
      5'd19:   code = {3'd1, 4'b0001};
      5'd20:   code = {3'd3, 4'b0100};
      5'd21:   code = {3'd4, 4'b1000};
      5'd22:   code = {3'd3, 4'b0110};
      5'd23:   code = {3'd4, 4'b1001};
      5'd24:   code = {3'd4, 4'b1101};
      5'd25:   code = {3'd4, 4'b0011};
      default: code = {3'd0, 4'b0000};
    endcase
    return code;
  endfunction

  // letter held by a tree node in heap order, a space at the root, zero where there is none
  function automatic logic [7:0] mcc_letter(input logic [NodeW-1:0] node);
    logic [7:0] ch;
    if (node[NodeW-1:5] != '0) begin
      ch = CHAR_NONE;
    end else begin
      case (node[4:0])
        5'd1:    ch = CHAR_SPACE;
        5'd2:    ch = "e";
        5'd3:    ch = "t";
        5'd4:    ch = "i";
        5'd5:    ch = "a";
        5'd6:    ch = "n";
        5'd7:    ch = "m";
        5'd8:    ch = "s";
        5'd9:    ch = "u";
        5'd10:   ch = "r";
        5'd11:   ch = "w";
        5'd12:   ch = "d";
        5'd13:   ch = "k";
        5'd14:   ch = "g";
        5'd15:   ch = "o";
        5'd16:   ch = "h";
        5'd17:   ch = "v";
        5'd18:   ch = "f";
        5'd20:   ch = "l";
        5'd22:   ch = "p";
        5'd23:   ch = "j";
        5'd24:   ch = "b";
        5'd25:   ch = "x";
        5'd26:   ch = "c";
        5'd27:   ch = "y";
        5'd28:   ch = "z";
        5'd29:   ch = "q";
        default: ch = CHAR_NONE;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mcc_core.sv
// translation of one character into its results, with tree and discard state
`default_nettype none

module mcc_core #(
  parameter int unsigned MAX_CODE_LEN = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           dir_i,
  input  wire logic [7:0]     char_i,
  input  wire logic           eos_i,
  input  wire logic           take_i,
  output mcc_pkg::burst_t     burst_o
);
  import mcc_pkg::*;

  localparam int unsigned TreeW = MAX_CODE_LEN + 1;
  localparam logic [TreeW-1:0] Root = TreeW'(1);

  logic [TreeW-1:0] pos_q, pos_d;
  logic             disc_q, disc_d;
  logic [6:0]       code;
  logic [2:0]       code_len;
  logic [3:0]       code_pat;
  logic [TreeW-1:0] next_pos;
  logic [7:0]       cur_letter, next_letter;
  logic             is_letter;
  logic             fail;

  // encode lookup
  assign is_letter = (char_i >= CHAR_A) && (char_i <= CHAR_Z);
  assign code      = mcc_code(5'(char_i - CHAR_A));
  assign code_len  = code[6:4];
  assign code_pat  = code[3:0];

  // decode tree step
  assign next_pos    = {pos_q[TreeW-2:0], (char_i == CHAR_DASH)};
  assign cur_letter  = mcc_letter(NodeW'(pos_q));
  assign next_letter = mcc_letter(NodeW'(next_pos));

  // results and next state for the item in the input register
  always_comb begin
    burst_o = '0;
    pos_d   = pos_q;
    disc_d  = disc_q;
    fail    = 1'b0;
    if (disc_q) begin
      if (eos_i) begin
        disc_d = 1'b0;
        pos_d  = Root;
      end
    end else if (!dir_i) begin
      if (char_i == CHAR_SPACE) begin
        burst_o.chars[0] = CHAR_SPACE;
        burst_o.cnt      = CntW'(1);
      end else if (is_letter) begin
        for (int i = 0; i < MaxResults; i++) begin
          if (i < int'(code_len)) begin
            burst_o.chars[i] = code_pat[2'(i)] ? CHAR_DASH : CHAR_DOT;
          end else if (i == int'(code_len)) begin
            burst_o.chars[i] = CHAR_SPACE;
          end
        end
        burst_o.cnt = CntW'(code_len) + CntW'(1);
      end else begin
        fail = 1'b1;
      end
      if (eos_i) begin
        pos_d = Root;
      end
    end else begin
      if (char_i == CHAR_SPACE) begin
        burst_o.chars[0] = cur_letter;
        burst_o.chars[1] = CHAR_SPACE;
        burst_o.cnt      = eos_i ? CntW'(2) : CntW'(1);
        pos_d            = Root;
      end else if (char_i == CHAR_DOT || char_i == CHAR_DASH) begin
        if (pos_q[TreeW-1] || next_letter == CHAR_NONE) begin
          fail = 1'b1;
        end else if (eos_i) begin
          burst_o.chars[0] = next_letter;
          burst_o.cnt      = CntW'(1);
          pos_d            = Root;
        end else begin
          pos_d = next_pos;
        end
      end else begin
        fail = 1'b1;
      end
    end
    // invalid input: one error result, drop the rest of the string
    if (fail) begin
      burst_o       = '0;
      burst_o.cnt   = CntW'(1);
      burst_o.err   = 1'b1;
      disc_d        = !eos_i;
      pos_d         = Root;
    end
  end

  // state moves on when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= Root;
      disc_q <= 1'b0;
    end else if (take_i) begin
      pos_q  <= pos_d;
      disc_q <= disc_d;
    end
  end

  `include "morse_code_codec_macros.svh"

  `MCC_ASSERT_IMP(a_disc_from_err, $rose(disc_q), $past(take_i) && $past(burst_o.err), "discard set without an error")
  `MCC_ASSERT_IMP(a_pos_nonzero, 1'b1, pos_q != '0, "tree position left the tree")

endmodule

`default_nettype wire

// File: hdl/mcc_emit.sv
// result register that hands out the results of one item, one per transfer
`default_nettype none

module mcc_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mcc_pkg::burst_t burst_i,
  input  wire logic            load_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 error_o,
  output logic                 last_o
);
  import mcc_pkg::*;

  burst_t          burst_q;
  logic [CntW-1:0] idx_q;
  logic            vld_q;
  logic            fire;

  assign fire        = vld_q && out_ready_i;
  assign out_valid_o = vld_q;
  assign out_char_o  = burst_q.chars[idx_q];
  assign error_o     = burst_q.err;
  assign last_o      = (idx_q == burst_q.cnt - CntW'(1));
  assign free_o      = !vld_q || (fire && last_o);

  // control: valid and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (fire) begin
      if (last_o) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + CntW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  `include "morse_code_codec_macros.svh"

  `MCC_ASSERT_IMP(a_idx_in_range, vld_q, burst_q.cnt != '0 && idx_q < burst_q.cnt && burst_q.cnt <= CntW'(MaxResults), "result index out of range")
  `MCC_ASSERT_IMP(a_err_alone, vld_q && burst_q.err, burst_q.cnt == CntW'(1) && out_char_o == CHAR_NONE, "error result not alone")
  `MCC_ASSERT_NXT(a_load_shows, load_i && burst_i.cnt != '0, vld_q && idx_q == '0, "loaded results not shown")

endmodule

`default_nettype wire

// File: hdl/morse_code_codec.sv
// top level of the morse code encoder and decoder
`default_nettype none

// Morse code codec, one ASCII character per input transfer. direction 0 encodes
// letters a to z into '.' and '_' symbols followed by a space; direction 1 walks
// the code tree on '.' and '_' and gives the letter reached on a space or at end
// of string. An invalid character or tree step gives one result with error set,
// and the rest of that string gives nothing. An item goes through an input
// register and is translated combinationally into a result register, which
// hands out one result per cycle while out_ready_i is high (up to five for an
// encoded letter); items that give no result (decode steps, discarded characters)
// go through at one per cycle. The next item is taken while results of the last
// one are still waiting; if it has results, it waits in the input register.
module morse_code_codec #(
  parameter int unsigned MAX_CODE_LEN = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_string_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            error_o,
  output logic            last_o
);
  import mcc_pkg::*;

  logic       dir_q;
  logic       item_vld_q;
  logic [7:0] char_q;
  logic       eos_q;
  burst_t     burst;
  logic       take;
  logic       load;
  logic       emit_free;

  // item leaves the input register when its results have a place to go
  assign take       = item_vld_q && (burst.cnt == '0 || emit_free);
  assign load       = take && burst.cnt != '0;
  assign in_ready_o = !item_vld_q || take;

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
      eos_q  <= end_of_string_i;
    end
  end

  mcc_core #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dir_i   (dir_q),
    .char_i  (char_q),
    .eos_i   (eos_q),
    .take_i  (take),
    .burst_o (burst)
  );

  mcc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .load_i      (load),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .error_o     (error_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
